// ----- hdl/mise_pkg.sv -----
// Shared types and constants for the MIPS integer subset execute block.
package mise_pkg;

  localparam logic [31:0] START_PC_RESET = 32'hBFC0_0000;
  localparam logic [31:0] JUMP_INDEX_MASK = 32'h03FF_FFFF;
  localparam logic [31:0] JUMP_REGION_MASK = 32'hF000_0000;
  localparam logic [31:0] HALF_MASK = 32'h0000_FFFF;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J = 6'h02;
  localparam logic [5:0] OP_BNE = 6'h05;
  localparam logic [5:0] OP_ADDI = 6'h08;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_ORI = 6'h0D;
  localparam logic [5:0] OP_LUI = 6'h0F;
  localparam logic [5:0] OP_COP0 = 6'h10;
  localparam logic [5:0] OP_COP3 = 6'h13;
  localparam logic [5:0] OP_LW = 6'h23;
  localparam logic [5:0] OP_SH = 6'h29;
  localparam logic [5:0] OP_SW = 6'h2B;

  localparam logic [5:0] FN_SLL = 6'h00;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_OR = 6'h25;
  localparam logic [5:0] FN_SLT = 6'h2A;
  localparam logic [5:0] FN_SLTU = 6'h2B;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_HALTED = 2'd1;
  localparam logic [1:0] ST_ORDER = 2'd2;

  localparam logic [1:0] MEM_NONE = 2'd0;
  localparam logic [1:0] MEM_READ_WORD = 2'd1;
  localparam logic [1:0] MEM_WRITE_WORD = 2'd2;
  localparam logic [1:0] MEM_WRITE_HALF = 2'd3;

  localparam logic [0:0] KIND_INSTR = 1'b0;
  localparam logic [0:0] KIND_LOAD = 1'b1;

  localparam logic [2:0] ADDR_START_PC = 3'd0;

  typedef struct packed {
    logic [31:0] pc;
    logic        delay_pending;
    logic [31:0] delay_target;
    logic        load_waiting;
    logic [4:0]  load_dest;
    logic        halted;
  } mise_state_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] next_fetch_addr;
    logic [1:0]  mem_op;
    logic [31:0] mem_addr;
    logic [31:0] mem_data;
  } mise_result_t;

  typedef struct packed {
    logic        en;
    logic [4:0]  addr;
    logic [31:0] data;
  } mise_wr_t;

endpackage

// ----- hdl/mise_regfile.sv -----
// Register file with reset valid bits, registered reads and write bypass.
module mise_regfile (
  input  logic               clk,
  input  logic               rst,
  input  logic               rd_en,
  input  logic [4:0]         rs_addr,
  input  logic [4:0]         rt_addr,
  input  mise_pkg::mise_wr_t wr,
  output logic [31:0]        rs_data,
  output logic [31:0]        rt_data
);
  import mise_pkg::*;

  logic [31:0] mem [32];
  logic [31:0] valid;
  logic [31:0] rs_raw;
  logic [31:0] rt_raw;
  logic [31:0] wr_fwd;
  logic        rs_hit;
  logic        rt_hit;
  logic        rs_live;
  logic        rt_live;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rs_raw  <= mem[rs_addr];
      rt_raw  <= mem[rt_addr];
      wr_fwd  <= wr.data;
      rs_hit  <= wr.en && (wr.addr == rs_addr);
      rt_hit  <= wr.en && (wr.addr == rt_addr);
      rs_live <= valid[rs_addr] && (rs_addr != 5'd0);
      rt_live <= valid[rt_addr] && (rt_addr != 5'd0);
    end
  end

  assign rs_data = rs_hit ? wr_fwd : (rs_live ? rs_raw : 32'd0);
  assign rt_data = rt_hit ? wr_fwd : (rt_live ? rt_raw : 32'd0);

endmodule

// ----- hdl/mise_exec.sv -----
// Decode and execute of one word: next state, result and register write.
module mise_exec (
  input  logic                   kind,
  input  logic [31:0]            instr_word,
  input  logic [31:0]            load_data,
  input  logic [31:0]            a,
  input  logic [31:0]            b,
  input  mise_pkg::mise_state_t  st,
  output mise_pkg::mise_state_t  st_next,
  output mise_pkg::mise_result_t res,
  output mise_pkg::mise_wr_t     wr
);
  import mise_pkg::*;

  logic [5:0]  opc;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  sa;
  logic [5:0]  fn;
  logic [31:0] imm;
  logic [31:0] simm;
  logic [31:0] pc_plus4;
  logic [31:0] tgt;
  logic [31:0] next;
  logic [31:0] ea;
  logic        take;
  logic        ok;
  logic        wen;
  logic [4:0]  waddr;
  logic [31:0] wdata;
  logic [1:0]  mop;
  logic [31:0] mdata;

  assign opc = instr_word[31:26];
  assign rt = instr_word[20:16];
  assign rd = instr_word[15:11];
  assign sa = instr_word[10:6];
  assign fn = instr_word[5:0];
  assign imm = instr_word & HALF_MASK;
  assign simm = {{16{instr_word[15]}}, instr_word[15:0]};
  assign pc_plus4 = st.pc + 32'd4;
  assign ea = a + simm;

  always_comb begin
    ok = 1'b1;
    take = 1'b0;
    tgt = pc_plus4 + {simm[29:0], 2'b00};
    wen = 1'b0;
    waddr = rt;
    wdata = 32'd0;
    mop = MEM_NONE;
    mdata = 32'd0;
    case (opc) inside
      OP_SPECIAL: begin
        waddr = rd;
        wen = 1'b1;
        case (fn)
          FN_SLL: wdata = b << sa;
          FN_ADDU: wdata = a + b;
          FN_OR: wdata = a | b;
          FN_SLT: wdata = {31'd0, $signed(a) < $signed(b)};
          FN_SLTU: wdata = {31'd0, a < b};
          default: begin
            ok = 1'b0;
            wen = 1'b0;
          end
        endcase
      end
      OP_J: begin
        take = 1'b1;
        tgt = (pc_plus4 & JUMP_REGION_MASK) | ((instr_word & JUMP_INDEX_MASK) << 2);
      end
      OP_BNE: take = (a != b);
      OP_ADDI, OP_ADDIU: begin
        wen = 1'b1;
        wdata = ea;
      end
      OP_ORI: begin
        wen = 1'b1;
        wdata = a | imm;
      end
      OP_LUI: begin
        wen = 1'b1;
        wdata = imm << 16;
      end
      [OP_COP0:OP_COP3]: ;
      OP_LW: mop = MEM_READ_WORD;
      OP_SH: begin
        mop = MEM_WRITE_HALF;
        mdata = b & HALF_MASK;
      end
      OP_SW: begin
        mop = MEM_WRITE_WORD;
        mdata = b;
      end
      default: ok = 1'b0;
    endcase
  end

  assign next = st.delay_pending ? st.delay_target : pc_plus4;

  always_comb begin
    st_next = st;
    res.status = ST_OK;
    res.next_fetch_addr = st.pc;
    res.mem_op = MEM_NONE;
    res.mem_addr = 32'd0;
    res.mem_data = 32'd0;
    wr.en = 1'b0;
    wr.addr = waddr;
    wr.data = wdata;
    if (st.halted) begin
      res.status = ST_HALTED;
    end else if (kind == KIND_LOAD) begin
      if (!st.load_waiting) begin
        res.status = ST_ORDER;
      end else begin
        st_next.load_waiting = 1'b0;
        wr.en = (st.load_dest != 5'd0);
        wr.addr = st.load_dest;
        wr.data = load_data;
      end
    end else if (st.load_waiting) begin
      res.status = ST_ORDER;
    end else if (!ok) begin
      st_next.halted = 1'b1;
      res.status = ST_HALTED;
    end else begin
      wr.en = wen && (waddr != 5'd0);
      st_next.pc = next;
      st_next.delay_pending = take;
      if (take) begin
        st_next.delay_target = tgt;
      end
      if (mop == MEM_READ_WORD) begin
        st_next.load_waiting = 1'b1;
        st_next.load_dest = rt;
      end
      res.next_fetch_addr = next;
      res.mem_op = mop;
      res.mem_addr = (mop == MEM_NONE) ? 32'd0 : ea;
      res.mem_data = mdata;
    end
  end

endmodule

// ----- hdl/mips_integer_subset_execute_top.sv -----
// Top level of the MIPS integer subset execute block.
//
//   channel | handshake          | contents
//   input   | in_valid/in_ready  | kind, instr_word, load_data
//   output  | out_valid/out_ready| status, next_fetch_addr, mem_op, mem_addr, mem_data
//   config  | APB psel/penable   | start_pc at byte address 0
//
// One word per cycle sustained while out_ready holds: an input register feeds decode
// and execute into the output register; register file reads start when a word is taken.
// An accepted word passes the input register, then the output register, to out_valid.
// A stalled output holds the input register; new words are taken as the output drains.
// Reset is synchronous and needs no clearing pass; the register file reads zero after it.
module mips_integer_subset_execute_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [31:0] instr_word,
  input  logic [31:0] load_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] next_fetch_addr,
  output logic [1:0]  mem_op,
  output logic [31:0] mem_addr,
  output logic [31:0] mem_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mise_pkg::*;

  logic         inq_valid;
  logic         inq_kind;
  logic [31:0]  inq_instr;
  logic [31:0]  inq_ldat;
  logic [31:0]  start_pc;
  mise_state_t  st;
  mise_state_t  st_next;
  mise_result_t res;
  mise_wr_t     wr;
  mise_wr_t     rf_wr;
  logic [31:0]  rs_data;
  logic [31:0]  rt_data;
  logic         fire;
  logic         take_in;
  logic         cfg_wr;

  assign fire = inq_valid && (!out_valid || out_ready);
  assign in_ready = !inq_valid || fire;
  assign take_in = in_valid && in_ready;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == ADDR_START_PC[2]);
  assign prdata = (paddr[2] == ADDR_START_PC[2]) ? start_pc : 32'd0;

  // commit a register write only when the held word advances
  assign rf_wr.en = wr.en && fire;
  assign rf_wr.addr = wr.addr;
  assign rf_wr.data = wr.data;

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (take_in) begin
      inq_valid <= 1'b1;
    end else if (fire) begin
      inq_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      inq_kind  <= kind;
      inq_instr <= instr_word;
      inq_ldat  <= load_data;
    end
  end

  mise_regfile u_regfile (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (take_in),
    .rs_addr (instr_word[25:21]),
    .rt_addr (instr_word[20:16]),
    .wr      (rf_wr),
    .rs_data (rs_data),
    .rt_data (rt_data)
  );

  mise_exec u_exec (
    .kind       (inq_kind),
    .instr_word (inq_instr),
    .load_data  (inq_ldat),
    .a          (rs_data),
    .b          (rt_data),
    .st         (st),
    .st_next    (st_next),
    .res        (res),
    .wr         (wr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      start_pc            <= START_PC_RESET;
      st.pc               <= START_PC_RESET;
      st.delay_pending    <= 1'b0;
      st.delay_target     <= 32'd0;
      st.load_waiting     <= 1'b0;
      st.load_dest        <= 5'd0;
      st.halted           <= 1'b0;
    end else if (cfg_wr) begin
      start_pc <= pwdata;
      st.pc    <= pwdata;
    end else if (fire) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status          <= res.status;
      next_fetch_addr <= res.next_fetch_addr;
      mem_op          <= res.mem_op;
      mem_addr        <= res.mem_addr;
      mem_data        <= res.mem_data;
    end
  end

endmodule

// ----- hdl/mise_checker.sv -----
// Port-level checks for the execute block, bound to its top level.
module mise_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [1:0]  mem_op,
  input logic [31:0] mem_addr,
  input logic [31:0] mem_data
);
  import mise_pkg::*;

  logic halt_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      halt_seen <= 1'b0;
    end else if (out_valid && out_ready && (status == ST_HALTED)) begin
      halt_seen <= 1'b1;
    end
  end

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && halt_seen |-> status == ST_HALTED)
    else $error("word after halt without halted status");

  a_no_mem_on_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> mem_op == MEM_NONE)
    else $error("memory access on a faulted word");

  a_idle_mem_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (mem_op == MEM_NONE) |-> (mem_addr == 32'd0) && (mem_data == 32'd0))
    else $error("memory fields not zero with no access");

  a_half_upper_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (mem_op == MEM_WRITE_HALF) |-> mem_data[31:16] == 16'd0)
    else $error("halfword store data above bit 15");

endmodule

bind mips_integer_subset_execute_top mise_checker u_mise_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .status    (status),
  .mem_op    (mem_op),
  .mem_addr  (mem_addr),
  .mem_data  (mem_data)
);

// ----- bench/mips_integer_subset_execute_top_test.sv -----
// Self-checking testbench for the MIPS integer subset execute block.
module mips_integer_subset_execute_top_test;
  import mise_pkg::*;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int WORDS_PER_PHASE = 100;
  localparam logic [31:0] BOOT = START_PC_RESET;

  typedef struct packed {
    logic         k;
    logic [31:0]  iw;
    logic [31:0]  ld;
    logic         typed;
    mise_result_t res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        kind = 1'b0;
  logic [31:0] instr_word = '0;
  logic [31:0] load_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [31:0] next_fetch_addr;
  logic [1:0]  mem_op;
  logic [31:0] mem_addr;
  logic [31:0] mem_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic [31:0] gpr [32];
  logic [31:0] boot_pc;
  logic [31:0] cur_pc;
  logic [31:0] br_target;
  logic        br_pending;
  logic        ld_wait;
  logic [4:0]  ld_dest;
  logic        stopped;

  mise_result_t pending_results [$];
  mise_result_t want;
  stim_row_t    directed [$];
  int           errors = 0;
  int           cycle_count = 0;
  int           send_idle_pct = 0;
  int           stall_pct = 0;
  int           idle_send [4] = '{0, 58, 0, 22};
  int           idle_recv [4] = '{0, 0, 58, 22};
  logic [31:0]  restart_pcs [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFC,
                                    32'h0000_0004, 32'hFFFF_FFFC, 32'hBFC0_0000, 32'h1234_5678};

  mips_integer_subset_execute_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(kind),
    .instr_word(instr_word),
    .load_data(load_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .next_fetch_addr(next_fetch_addr),
    .mem_op(mem_op),
    .mem_addr(mem_addr),
    .mem_data(mem_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #2 clk = ~clk;

  function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                        logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [31:0] enc_r(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                        logic [4:0] sa, logic [5:0] fn);
    return {OP_SPECIAL, rs, rt, rd, sa, fn};
  endfunction

  function automatic logic [31:0] enc_j(logic [25:0] idx);
    return {OP_J, idx};
  endfunction

  function automatic logic [31:0] sext_imm(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [4:0] pick_reg();
    logic [31:0] t;
    t = $urandom;
    if (t[31]) t[4:3] = 2'b00;
    return t[4:0];
  endfunction

  function automatic logic [15:0] pick_imm();
    logic [31:0] t;
    t = $urandom;
    case (t[31:29])
      3'd0: t[15:0] = 16'h0000;
      3'd1: t[15:0] = 16'hFFFF;
      3'd2: t[15:0] = 16'h7FFF;
      3'd3: t[15:0] = 16'h8000;
      default: ;
    endcase
    return t[15:0];
  endfunction

  task automatic execute_word(input logic k, input logic [31:0] iw, input logic [31:0] ld,
                              output mise_result_t res);
    logic [5:0]  op;
    logic [5:0]  fn;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sa;
    logic [4:0]  wdst;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] wval;
    logic [31:0] tgt;
    logic [31:0] nxt;
    logic        wr;
    logic        take;
    logic        bad;
    res = '0;
    res.status = ST_OK;
    res.next_fetch_addr = cur_pc;
    if (stopped) begin
      res.status = ST_HALTED;
    end else if (k == KIND_LOAD) begin
      if (!ld_wait) begin
        res.status = ST_ORDER;
      end else begin
        if (ld_dest != 5'd0) gpr[ld_dest] = ld;
        ld_wait = 1'b0;
      end
    end else if (ld_wait) begin
      res.status = ST_ORDER;
    end else begin
      op = iw[31:26];
      rs = iw[25:21];
      rt = iw[20:16];
      rd = iw[15:11];
      sa = iw[10:6];
      fn = iw[5:0];
      a = gpr[rs];
      b = gpr[rt];
      wr = 1'b0;
      take = 1'b0;
      bad = 1'b0;
      wdst = rt;
      wval = '0;
      tgt = '0;
      case (op)
        OP_SPECIAL: begin
          wdst = rd;
          wr = 1'b1;
          case (fn)
            FN_SLL: wval = b << sa;
            FN_ADDU: wval = a + b;
            FN_OR: wval = a | b;
            FN_SLT: wval = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            FN_SLTU: wval = (a < b) ? 32'd1 : 32'd0;
            default: begin
              wr = 1'b0;
              bad = 1'b1;
            end
          endcase
        end
        OP_J: begin
          take = 1'b1;
          tgt = ((cur_pc + 32'd4) & JUMP_REGION_MASK) | ((iw & JUMP_INDEX_MASK) << 2);
        end
        OP_BNE: begin
          if (a != b) begin
            take = 1'b1;
            tgt = cur_pc + 32'd4 + (sext_imm(iw[15:0]) << 2);
          end
        end
        OP_ADDI, OP_ADDIU: begin
          wr = 1'b1;
          wval = a + sext_imm(iw[15:0]);
        end
        OP_ORI: begin
          wr = 1'b1;
          wval = a | (iw & HALF_MASK);
        end
        OP_LUI: begin
          wr = 1'b1;
          wval = {iw[15:0], 16'h0000};
        end
        OP_LW: begin
          res.mem_op = MEM_READ_WORD;
          res.mem_addr = a + sext_imm(iw[15:0]);
        end
        OP_SH: begin
          res.mem_op = MEM_WRITE_HALF;
          res.mem_addr = a + sext_imm(iw[15:0]);
          res.mem_data = b & HALF_MASK;
        end
        OP_SW: begin
          res.mem_op = MEM_WRITE_WORD;
          res.mem_addr = a + sext_imm(iw[15:0]);
          res.mem_data = b;
        end
        default: bad = !(op >= OP_COP0 && op <= OP_COP3);
      endcase
      if (bad) begin
        stopped = 1'b1;
        res.status = ST_HALTED;
      end else begin
        if (wr && wdst != 5'd0) gpr[wdst] = wval;
        if (br_pending) begin
          nxt = br_target;
          br_pending = 1'b0;
        end else begin
          nxt = cur_pc + 32'd4;
        end
        if (take) begin
          br_pending = 1'b1;
          br_target = tgt;
        end
        if (op == OP_LW) begin
          ld_wait = 1'b1;
          ld_dest = rt;
        end
        cur_pc = nxt;
        res.next_fetch_addr = nxt;
      end
    end
  endtask

  task automatic random_instr(output logic [31:0] iw);
    logic [31:0] noise;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [15:0] imm;
    noise = $urandom;
    rs = pick_reg();
    rt = pick_reg();
    rd = pick_reg();
    imm = pick_imm();
    case ($urandom_range(14))
      0: iw = enc_i(OP_LUI, noise[25:21], rt, imm);
      1: iw = enc_i(OP_ORI, rs, rt, imm);
      2: iw = enc_i(OP_ADDI, rs, rt, imm);
      3: iw = enc_i(OP_ADDIU, rs, rt, imm);
      4: iw = enc_r(rs, rt, rd, noise[10:6], FN_SLL);
      5: iw = enc_r(rs, rt, rd, noise[10:6], FN_ADDU);
      6: iw = enc_r(rs, rt, rd, noise[10:6], FN_OR);
      7: iw = enc_r(rs, rt, rd, noise[10:6], FN_SLT);
      8: iw = enc_r(rs, rt, rd, noise[10:6], FN_SLTU);
      9: iw = enc_i(OP_BNE, rs, noise[0] ? rs : rt, imm);
      10: iw = enc_j(noise[25:0]);
      11: iw = {OP_COP0[5:2], noise[27:26], noise[25:0]};
      12: iw = enc_i(OP_LW, rs, rt, imm);
      13: iw = enc_i(OP_SW, rs, rt, imm);
      default: iw = enc_i(OP_SH, rs, rt, imm);
    endcase
  endtask

  task automatic bad_instr(output logic [31:0] iw);
    logic [31:0] t;
    bit          known;
    do begin
      t = $urandom;
      known = 1'b1;
      if (t[0] ^ t[31]) begin
        t[31:26] = OP_SPECIAL;
        case (t[5:0])
          FN_SLL, FN_ADDU, FN_OR, FN_SLT, FN_SLTU: known = 1'b1;
          default: known = 1'b0;
        endcase
      end else begin
        case (t[31:26])
          OP_SPECIAL, OP_J, OP_BNE, OP_ADDI, OP_ADDIU, OP_ORI, OP_LUI, OP_LW, OP_SH, OP_SW:
            known = 1'b1;
          default: known = (t[31:26] >= OP_COP0 && t[31:26] <= OP_COP3);
        endcase
      end
    end while (known);
    iw = t;
  endtask

  task automatic next_item(output logic k, output logic [31:0] iw, output logic [31:0] ld);
    int r;
    r = $urandom_range(99);
    ld = $urandom;
    case ($urandom_range(7))
      0: ld = 32'h0000_0000;
      1: ld = 32'hFFFF_FFFF;
      2: ld = 32'h8000_0000;
      default: ;
    endcase
    iw = $urandom;
    k = KIND_INSTR;
    if (ld_wait ? (r < 85) : (r < 4)) k = KIND_LOAD;
    else random_instr(iw);
  endtask

  task automatic send_word(input logic k, input logic [31:0] iw, input logic [31:0] ld,
                           input logic typed, input mise_result_t typed_res,
                           output logic [1:0] st);
    mise_result_t res;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    kind <= k;
    instr_word <= iw;
    load_data <= ld;
    do @(posedge clk); while (!in_ready);
    execute_word(k, iw, ld, res);
    pending_results.push_back(typed ? typed_res : res);
    st = res.status;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_start_pc(input logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_START_PC;
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== v) begin
      $display("%0t: start_pc readback expected %h, got %h", $time, v, prdata);
      errors++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    boot_pc = v;
    cur_pc = v;
  endtask

  task automatic add_row(input logic k, input logic [31:0] iw, input logic [31:0] ld,
                         input logic [1:0] st, input logic [31:0] nf, input logic [1:0] mop,
                         input logic [31:0] ma, input logic [31:0] md);
    stim_row_t row;
    row.k = k;
    row.iw = iw;
    row.ld = ld;
    row.typed = 1'b1;
    row.res.status = st;
    row.res.next_fetch_addr = nf;
    row.res.mem_op = mop;
    row.res.mem_addr = ma;
    row.res.mem_data = md;
    directed.push_back(row);
  endtask

  task automatic cmp_field(input string what, input logic [31:0] exp_v, input logic [31:0] got);
    if (got !== exp_v) begin
      $display("%0t: %s expected %h, got %h", $time, what, exp_v, got);
      errors++;
    end
  endtask

  always @(negedge clk) begin
    out_ready <= (stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected, status %h addr %h", $time, status,
                 next_fetch_addr);
        errors++;
      end else begin
        want = pending_results.pop_front();
        cmp_field("status", 32'(want.status), 32'(status));
        cmp_field("next_fetch_addr", want.next_fetch_addr, next_fetch_addr);
        cmp_field("mem_op", 32'(want.mem_op), 32'(mem_op));
        cmp_field("mem_addr", want.mem_addr, mem_addr);
        cmp_field("mem_data", want.mem_data, mem_data);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("mips_integer_subset_execute_top verification failed");
      $finish;
    end
  end

  initial begin
    int           ph;
    int           done;
    logic         k;
    logic [31:0]  iw;
    logic [31:0]  ld;
    logic [1:0]   st;
    mise_result_t no_res;
    no_res = '0;
    foreach (gpr[i]) gpr[i] = '0;
    boot_pc = START_PC_RESET;
    cur_pc = boot_pc;
    br_pending = 1'b0;
    br_target = '0;
    ld_wait = 1'b0;
    ld_dest = '0;
    stopped = 1'b0;

    add_row(KIND_LOAD, 32'hFFFF_FFFF, 32'h1234_5678, ST_ORDER, BOOT, MEM_NONE, 0, 0);
    add_row(KIND_INSTR, enc_i(OP_LUI, 5'd0, 5'd1, 16'hFFFF), 0, ST_OK, BOOT + 32'h04,
            MEM_NONE, 0, 0);
    add_row(KIND_INSTR, enc_i(OP_ORI, 5'd1, 5'd1, 16'hFFFF), 0, ST_OK, BOOT + 32'h08,
            MEM_NONE, 0, 0);
    add_row(KIND_INSTR, enc_i(OP_ADDIU, 5'd0, 5'd2, 16'h7FFF), 0, ST_OK, BOOT + 32'h0C,
            MEM_NONE, 0, 0);
    add_row(KIND_INSTR, enc_i(OP_ADDI, 5'd1, 5'd3, 16'h0001), 0, ST_OK, BOOT + 32'h10,
            MEM_NONE, 0, 0);
    add_row(KIND_INSTR, enc_i(OP_ADDI, 5'd2, 5'd4, 16'h8000), 0, ST_OK, BOOT + 32'h14,
            MEM_NONE, 0, 0);
    add_row(KIND_INSTR, enc_r(5'd1, 5'd2, 5'd5, 5'd0, FN_ADDU), 0, ST_OK, BOOT + 32'h18,
            MEM_NONE, 0, 0);
    add_row(KIND_INSTR, enc_r(5'd1, 5'd2, 5'd6, 5'd0, FN_OR), 0, ST_OK, BOOT + 32'h1C,
            MEM_NONE, 0, 0);
    add_row(KIND_INSTR, enc_r(5'd0, 5'd2, 5'd7, 5'd31, FN_SLL), 0, ST_OK, BOOT + 32'h20,
            MEM_NONE, 0, 0);
    add_row(KIND_INSTR, enc_r(5'd7, 5'd2, 5'd8, 5'd0, FN_SLT), 0, ST_OK, BOOT + 32'h24,
            MEM_NONE, 0, 0);
    add_row(KIND_INSTR, enc_r(5'd7, 5'd2, 5'd9, 5'd0, FN_SLTU), 0, ST_OK, BOOT + 32'h28,
            MEM_NONE, 0, 0);
    add_row(KIND_INSTR, enc_i(OP_SW, 5'd2, 5'd1, 16'hFFFC), 0, ST_OK, BOOT + 32'h2C,
            MEM_WRITE_WORD, 32'h0000_7FFB, 32'hFFFF_FFFF);
    add_row(KIND_INSTR, enc_i(OP_SH, 5'd1, 5'd1, 16'h7FFF), 0, ST_OK, BOOT + 32'h30,
            MEM_WRITE_HALF, 32'h0000_7FFE, 32'h0000_FFFF);
    add_row(KIND_INSTR, enc_i(OP_LW, 5'd0, 5'd10, 16'h0000), 0, ST_OK, BOOT + 32'h34,
            MEM_READ_WORD, 0, 0);
    add_row(KIND_INSTR, enc_i(OP_LUI, 5'd0, 5'd1, 16'hFFFF), 0, ST_ORDER, BOOT + 32'h34,
            MEM_NONE, 0, 0);
    add_row(KIND_LOAD, 32'h0000_0000, 32'hDEAD_BEEF, ST_OK, BOOT + 32'h34, MEM_NONE, 0, 0);
    add_row(KIND_INSTR, enc_i(OP_LW, 5'd0, 5'd0, 16'h0004), 0, ST_OK, BOOT + 32'h38,
            MEM_READ_WORD, 32'h0000_0004, 0);
    add_row(KIND_LOAD, 32'h0000_0000, 32'hFFFF_FFFF, ST_OK, BOOT + 32'h38, MEM_NONE, 0, 0);
    add_row(KIND_INSTR, {OP_COP3, 26'h3FF_FFFF}, 0, ST_OK, BOOT + 32'h3C, MEM_NONE, 0, 0);
    add_row(KIND_INSTR, enc_i(OP_BNE, 5'd1, 5'd2, 16'h0003), 0, ST_OK, BOOT + 32'h40,
            MEM_NONE, 0, 0);
    add_row(KIND_INSTR, enc_j(26'h3FF_FFFF), 0, ST_OK, BOOT + 32'h4C, MEM_NONE, 0, 0);
    add_row(KIND_INSTR, enc_i(OP_ORI, 5'd1, 5'd0, 16'h0000), 0, ST_OK, 32'hBFFF_FFFC,
            MEM_NONE, 0, 0);
    add_row(KIND_INSTR, enc_i(OP_BNE, 5'd1, 5'd1, 16'h0005), 0, ST_OK, 32'hC000_0000,
            MEM_NONE, 0, 0);
    add_row(KIND_INSTR, enc_i(OP_BNE, 5'd1, 5'd0, 16'hFFFF), 0, ST_OK, 32'hC000_0004,
            MEM_NONE, 0, 0);
    add_row(KIND_INSTR, enc_i(OP_SW, 5'd0, 5'd10, 16'h0000), 0, ST_OK, 32'hC000_0000,
            MEM_WRITE_WORD, 0, 32'hDEAD_BEEF);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed[i]) begin
      send_word(directed[i].k, directed[i].iw, directed[i].ld, directed[i].typed,
                directed[i].res, st);
    end
    drain();

    for (ph = 0; ph < 8; ph++) begin
      write_start_pc(ph == 7 ? $urandom : restart_pcs[ph]);
      send_idle_pct = idle_send[ph % 4];
      stall_pct = idle_recv[ph % 4];
      done = 0;
      while (done < WORDS_PER_PHASE) begin
        next_item(k, iw, ld);
        send_word(k, iw, ld, 1'b0, no_res, st);
        if (st == ST_OK) done++;
      end
      drain();
    end

    // run into an unimplemented opcode, then confirm the block stays halted
    send_idle_pct = idle_send[3];
    stall_pct = idle_recv[3];
    repeat (6) begin
      next_item(k, iw, ld);
      send_word(k, iw, ld, 1'b0, no_res, st);
    end
    if (ld_wait) send_word(KIND_LOAD, $urandom, $urandom, 1'b0, no_res, st);
    bad_instr(iw);
    send_word(KIND_INSTR, iw, $urandom, 1'b0, no_res, st);
    repeat (6) begin
      next_item(k, iw, ld);
      send_word(k, iw, ld, 1'b0, no_res, st);
    end
    drain();
    repeat (8) @(posedge clk);

    if (errors == 0) begin
      $display("mips_integer_subset_execute_top verification clean");
    end else begin
      $display("mips_integer_subset_execute_top verification failed");
    end
    $finish;
  end

endmodule
